>>> design/dbn_pkg.sv
`timescale 1ns / 1ps
// Package: widths, configuration codes and payload types for the debounced I/O node.
package dbn_pkg;

    localparam int CHANNELS = 8;

    localparam int CNT_W   = 8;
    localparam int TIMER_W = 13;
    localparam int BLINK_W = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_CAP       = 3'd1,
        CFG_RELOAD    = 3'd2,
        CFG_LEVEL     = 3'd3,
        CFG_RCAP      = 3'd4,
        CFG_BLINK     = 3'd5
    } cfg_idx_t;

    typedef enum logic {
        KIND_TICK = 1'b0,
        KIND_POLL = 1'b1
    } kind_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] raw_inputs;
        logic [7:0] command_bits;
        logic [7:0] remote_echo;
        logic       tx_ready;
        logic       tx_confirmed;
    } item_t;

    typedef struct packed {
        logic [7:0] output_pins;
        logic [7:0] debounced_inputs;
        logic       send_valid;
        logic [7:0] send_data;
        logic       heartbeat_led;
    } result_t;

    localparam logic [TIMER_W-1:0] RST_RELOAD    = 13'd1600;
    localparam logic [TIMER_W-1:0] RST_LEVEL     = 13'd1500;
    localparam logic [TIMER_W-1:0] RST_RCAP      = 13'd5000;
    localparam logic [CNT_W-1:0]   RST_THRESHOLD = 8'd20;
    localparam logic [CNT_W-1:0]   RST_CAP       = 8'd250;
    localparam logic [BLINK_W-1:0] RST_BLINK     = 10'd1000;

endpackage

>>> design/dbn_if.sv
`timescale 1ns / 1ps
// Interfaces: item, result and configuration write channels of the debounced I/O node.
interface dbn_item_if;
    logic           valid;
    logic           ready;
    dbn_pkg::item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dbn_result_if;
    logic             valid;
    logic             ready;
    dbn_pkg::result_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dbn_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [dbn_pkg::CFG_IDX_W-1:0]    index;
    logic [dbn_pkg::CFG_DATA_W-1:0]   wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

>>> design/debounced_io_node_with_change_report.sv
`timescale 1ns / 1ps
// Top level: eight-channel input debouncer with output latch, change report and heartbeat.
//
//   channel  | direction | payload                                      | role
//   ---------+-----------+----------------------------------------------+----------------------
//   item     | sink      | kind, raw_inputs, command_bits, remote_echo, | tick or service poll
//            |           | tx_ready, tx_confirmed                       |
//   result   | source    | output_pins, debounced_inputs, send_valid,   | one per request
//            |           | send_data, heartbeat_led                     |
//   cfg      | sink      | index, wdata                                 | register write
//
// Each request passes through two registers: the input register, then the result
// register. One request is taken per cycle while the result is not stalled; the state
// update of one request feeds the next through the node state registers.
// Reset clears all node state and loads the default register values; no clearing pass.
// A stalled result holds the result register; the input register advances only when
// the result register is free or being drained in the same cycle.
module debounced_io_node_with_change_report (
    input  logic                clk,
    input  logic                rst_n,
    dbn_item_if.sink            item,
    dbn_result_if.source        result,
    dbn_cfg_if.sink             cfg
);

    // Configuration registers.
    logic [dbn_pkg::CNT_W-1:0]   thr_reg;
    logic [dbn_pkg::CNT_W-1:0]   cap_reg;
    logic [dbn_pkg::TIMER_W-1:0] reload_reg;
    logic [dbn_pkg::TIMER_W-1:0] level_reg;
    logic [dbn_pkg::TIMER_W-1:0] rcap_reg;
    logic [dbn_pkg::BLINK_W-1:0] blink_reg;

    // Node state.
    logic [dbn_pkg::CHANNELS-1:0] last_reg, last_next;
    logic [dbn_pkg::CHANNELS-1:0] stable_reg, stable_next;
    logic [dbn_pkg::CNT_W-1:0]    cnt_reg  [dbn_pkg::CHANNELS];
    logic [dbn_pkg::CNT_W-1:0]    cnt_next [dbn_pkg::CHANNELS];
    logic [dbn_pkg::TIMER_W-1:0]  timer_reg, timer_next;
    logic [dbn_pkg::BLINK_W-1:0]  blink_cnt_reg, blink_cnt_next;
    logic                         led_reg, led_next;
    logic [7:0]                   pin_reg, pin_next;

    // Pipeline registers.
    logic             in_valid_reg;
    dbn_pkg::item_t   in_data_reg;
    logic             out_valid_reg;
    dbn_pkg::result_t out_data_reg, out_data_next;

    logic out_free;
    logic advance;

    // The result register is free when empty or drained this cycle; the input register
    // advances into it whenever it holds a request and the result side is free.
    assign out_free   = !out_valid_reg || result.ready;
    assign advance    = in_valid_reg && out_free;
    assign item.ready = !in_valid_reg || out_free;
    assign cfg.ready  = 1'b1;

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // Configuration writes; indexes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= dbn_pkg::RST_THRESHOLD;
            cap_reg    <= dbn_pkg::RST_CAP;
            reload_reg <= dbn_pkg::RST_RELOAD;
            level_reg  <= dbn_pkg::RST_LEVEL;
            rcap_reg   <= dbn_pkg::RST_RCAP;
            blink_reg  <= dbn_pkg::RST_BLINK;
        end
        else if (cfg.valid)
        begin
            case (dbn_pkg::cfg_idx_t'(cfg.index))
                dbn_pkg::CFG_THRESHOLD: thr_reg    <= cfg.wdata[dbn_pkg::CNT_W-1:0];
                dbn_pkg::CFG_CAP:       cap_reg    <= cfg.wdata[dbn_pkg::CNT_W-1:0];
                dbn_pkg::CFG_RELOAD:    reload_reg <= cfg.wdata[dbn_pkg::TIMER_W-1:0];
                dbn_pkg::CFG_LEVEL:     level_reg  <= cfg.wdata[dbn_pkg::TIMER_W-1:0];
                dbn_pkg::CFG_RCAP:      rcap_reg   <= cfg.wdata[dbn_pkg::TIMER_W-1:0];
                dbn_pkg::CFG_BLINK:     blink_reg  <= cfg.wdata[dbn_pkg::BLINK_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register: take a request whenever the stage is empty or advancing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (item.ready)
            in_valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
            in_data_reg <= item.data;
    end

    // Request processing: all channels in parallel, then the report timer decision.
    always_comb
    begin
        logic [dbn_pkg::TIMER_W-1:0] timer_mid;
        logic [dbn_pkg::BLINK_W:0]   blink_inc;
        logic                        send;

        last_next      = last_reg;
        stable_next    = stable_reg;
        timer_next     = timer_reg;
        blink_cnt_next = blink_cnt_reg;
        led_next       = led_reg;
        pin_next       = pin_reg;
        timer_mid      = timer_reg;
        send           = 1'b0;
        blink_inc      = {1'b0, blink_cnt_reg} + 1'b1;
        for (int i = 0; i < dbn_pkg::CHANNELS; i++)
            cnt_next[i] = cnt_reg[i];

        if (in_data_reg.kind == dbn_pkg::KIND_POLL)
        begin
            pin_next = in_data_reg.command_bits;
            for (int i = 0; i < dbn_pkg::CHANNELS; i++)
            begin
                if (last_reg[i] == in_data_reg.raw_inputs[i])
                begin
                    // Sample held steady: accept it once the count passes the threshold.
                    if (cnt_reg[i] > thr_reg)
                        stable_next[i] = in_data_reg.raw_inputs[i];
                end
                else
                begin
                    // Sample moved: remember it and restart the count.
                    last_next[i] = in_data_reg.raw_inputs[i];
                    cnt_next[i]  = '0;
                end
            end

            // Host copy out of date: rearm the report timer.
            if (stable_next != in_data_reg.remote_echo)
                timer_mid = reload_reg;

            send = (timer_mid >= level_reg) && in_data_reg.tx_ready;
            if (send && in_data_reg.tx_confirmed)
                timer_next = '0;
            else
                timer_next = timer_mid;
        end
        else
        begin
            // Tick: advance saturating counters; a counter at or above its cap holds.
            if (timer_reg < rcap_reg)
                timer_next = timer_reg + 1'b1;
            for (int i = 0; i < dbn_pkg::CHANNELS; i++)
            begin
                if (cnt_reg[i] < cap_reg)
                    cnt_next[i] = cnt_reg[i] + 1'b1;
            end
            // Heartbeat: compare the incremented count at full width.
            if (blink_inc > {1'b0, blink_reg})
            begin
                blink_cnt_next = '0;
                led_next       = !led_reg;
            end
            else
            begin
                blink_cnt_next = blink_inc[dbn_pkg::BLINK_W-1:0];
            end
        end

        out_data_next.output_pins      = pin_next;
        out_data_next.debounced_inputs = stable_next;
        out_data_next.send_valid       = send;
        out_data_next.send_data        = send ? stable_next : 8'd0;
        out_data_next.heartbeat_led    = led_next;
    end

    // Node state: commit only when a request advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg      <= '0;
            stable_reg    <= '0;
            timer_reg     <= '0;
            blink_cnt_reg <= '0;
            led_reg       <= 1'b0;
            pin_reg       <= '0;
            for (int i = 0; i < dbn_pkg::CHANNELS; i++)
                cnt_reg[i] <= '0;
        end
        else if (advance)
        begin
            last_reg      <= last_next;
            stable_reg    <= stable_next;
            timer_reg     <= timer_next;
            blink_cnt_reg <= blink_cnt_next;
            led_reg       <= led_next;
            pin_reg       <= pin_next;
            for (int i = 0; i < dbn_pkg::CHANNELS; i++)
                cnt_reg[i] <= cnt_next[i];
        end
    end

    // Result register: load on advance, drop once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= advance;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= out_data_next;
    end

endmodule
